@@ design/generalized_time_to_epoch_seconds_unit_defines.svh @@
// Assertion macros for the time conversion design files, used by the converter.
`ifndef GENERALIZED_TIME_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH
`define GENERALIZED_TIME_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GTES_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTES_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GTES_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTES_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ design/gtes_pkg.sv @@
// Types, constants and the month table for the time conversion unit.
package gtes_pkg;

	localparam logic [3:0]  TIME_CHARS         = 4'd14;
	localparam logic [7:0]  CHAR_ZERO          = 8'h30;
	localparam logic [7:0]  CHAR_NINE          = 8'h39;
	localparam logic [13:0] EPOCH_YEAR         = 14'd1970;
	localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;
	localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
	localparam logic [12:0] RECIP_100          = 13'd5243;
	localparam int          RECIP_SHIFT        = 19;
	localparam logic [13:0] CENTURY_LAST_REM   = 14'd99;
	localparam logic [3:0]  MONTH_FEB          = 4'd2;
	localparam logic [6:0]  MONTH_MAX          = 7'd12;
	localparam logic [6:0]  DAY_MAX            = 7'd31;
	localparam int          QUEUE_DEPTH        = 2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [37:0] seconds;
		logic        ok;
	} out_word_t;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic        ok;
	} date_rec_t;

	// Days before the first of the given month in a common year.
	function automatic logic [8:0] month_offset(input logic [3:0] month);
		logic [8:0] days;
		unique case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

@@ design/gtes_front.sv @@
// Character front end: checks digits and builds the date fields of one string.
module gtes_front import gtes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_word_t  item,
	output logic      rec_push,
	output date_rec_t rec
);

	logic [3:0]  pos_q, pos_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  month_q, month_n, day_q, day_n;
	logic [6:0]  hour_q, hour_n, minute_q, minute_n, second_q, second_n;
	logic        bad_q, bad_n;
	logic        is_digit;
	logic [3:0]  digit;

	function automatic logic [6:0] shift_in7(input logic [6:0] acc, input logic [3:0] d);
		return 7'((11'(acc) << 3) + (11'(acc) << 1) + 11'(d));
	endfunction

	always_comb begin
		is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
		digit    = 4'(item.char_code - CHAR_ZERO);
		pos_n    = pos_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		bad_n    = bad_q;
		if (pos_q < TIME_CHARS) begin
			if (!is_digit) begin
				bad_n = 1'b1;
			end else begin
				priority if (pos_q < 4'd4) begin
					year_n = 14'((18'(year_q) << 3) + (18'(year_q) << 1) + 18'(digit));
				end else if (pos_q < 4'd6) begin
					month_n = shift_in7(month_q, digit);
				end else if (pos_q < 4'd8) begin
					day_n = shift_in7(day_q, digit);
				end else if (pos_q < 4'd10) begin
					hour_n = shift_in7(hour_q, digit);
				end else if (pos_q < 4'd12) begin
					minute_n = shift_in7(minute_q, digit);
				end else begin
					second_n = shift_in7(second_q, digit);
				end
			end
			pos_n = pos_q + 4'd1;
		end
	end

	always_comb begin
		rec.year   = year_n;
		rec.month  = month_n;
		rec.day    = day_n;
		rec.hour   = hour_n;
		rec.minute = minute_n;
		rec.second = second_n;
		rec.ok     = (pos_n == TIME_CHARS) && !bad_n &&
			(month_n >= 7'd1) && (month_n <= MONTH_MAX) &&
			(day_n >= 7'd1) && (day_n <= DAY_MAX);
		rec_push   = accept && item.is_last;
	end

	// The last character closes the string, so the fields start over from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			bad_q    <= 1'b0;
		end else if (accept) begin
			if (item.is_last) begin
				pos_q    <= '0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				bad_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				bad_q    <= bad_n;
			end
		end
	end

endmodule

@@ design/gtes_queue.sv @@
// Short queue of parsed dates between the front end and the converter.
module gtes_queue import gtes_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  date_rec_t wr_data,
	output logic      full,
	input  logic      rd_en,
	output date_rec_t rd_data,
	output logic      empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	date_rec_t      mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ design/gtes_back.sv @@
// Converter: turns one parsed date into seconds since 1970 over several steps.
`include "generalized_time_to_epoch_seconds_unit_defines.svh"
module gtes_back import gtes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	input  date_rec_t rec,
	output logic      rec_take,
	output out_word_t result,
	output logic      empty,
	input  logic      pop
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_QUOT  = 7'b0000010,
		ST_LEAP  = 7'b0000100,
		ST_DAYS  = 7'b0001000,
		ST_HOURS = 7'b0010000,
		ST_MINS  = 7'b0100000,
		ST_SECS  = 7'b1000000
	} state_t;

	state_t      state_q;
	date_rec_t   rec_q;
	logic [13:0] ym1_q;
	logic [7:0]  q100_q;
	logic [11:0] leaps_q;
	logic        leap_q;
	logic [21:0] days_q;
	logic [37:0] acc_q;
	out_word_t   result_q;
	logic        out_valid_q;

	logic [13:0] ym1;
	logic [26:0] prod;
	logic [13:0] rem;
	logic [12:0] dyears;
	logic [21:0] ydays, days_n;
	logic [37:0] final_secs;
	logic        slot_free;

	always_comb begin
		ym1        = rec_q.year - 14'd1;
		prod       = 27'(ym1) * 27'(RECIP_100);
		rem        = 14'(ym1_q - 14'(q100_q) * 14'd100);
		dyears     = 13'(rec_q.year - EPOCH_YEAR);
		ydays      = (rec_q.year > EPOCH_YEAR) ?
			22'(dyears) * 22'(DAYS_PER_YEAR) + 22'(leaps_q) - 22'(LEAPS_BEFORE_EPOCH) : '0;
		days_n     = ydays + 22'(month_offset(rec_q.month[3:0])) +
			22'(leap_q && (rec_q.month > 7'(MONTH_FEB))) + 22'(rec_q.day) - 22'd1;
		final_secs = (acc_q << 6) - (acc_q << 2) + 38'(rec_q.second);
		slot_free  = !out_valid_q || pop;
		rec_take   = (state_q == ST_IDLE) && rec_valid;
	end

	assign result = result_q;
	assign empty  = !out_valid_q;

	// Year quotients by 100 come from a reciprocal multiply; exact below 43690.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (rec_valid) begin
					rec_q <= rec;
				end
			end
			ST_QUOT: begin
				ym1_q  <= ym1;
				q100_q <= prod[RECIP_SHIFT +: 8];
			end
			ST_LEAP: begin
				leaps_q <= 12'(ym1_q >> 2) - 12'(q100_q) + 12'(q100_q >> 2);
				// The year is a century year when the year before it ends in 99.
				leap_q  <= (rec_q.year[1:0] == 2'b00) &&
					((rem != CENTURY_LAST_REM) || (q100_q[1:0] == 2'b11));
			end
			ST_DAYS: begin
				days_q <= days_n;
			end
			ST_HOURS: begin
				acc_q <= (38'(days_q) << 4) + (38'(days_q) << 3) + 38'(rec_q.hour);
			end
			ST_MINS: begin
				acc_q <= (acc_q << 6) - (acc_q << 2) + 38'(rec_q.minute);
			end
			ST_SECS: begin
				if (slot_free) begin
					result_q.seconds <= rec_q.ok ? final_secs : '0;
					result_q.ok      <= rec_q.ok;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_SECS) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (rec_valid) state_q <= ST_QUOT;
				ST_QUOT:  state_q <= ST_LEAP;
				ST_LEAP:  state_q <= ST_DAYS;
				ST_DAYS:  state_q <= ST_HOURS;
				ST_HOURS: state_q <= ST_MINS;
				ST_MINS:  state_q <= ST_SECS;
				ST_SECS:  if (slot_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	`GTES_ASSERT(a_reject_zero, clk, arst_n, out_valid_q && !result_q.ok |-> result_q.seconds == '0, "rejected word carries nonzero seconds")
	`GTES_ASSERT(a_valid_from_secs, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_SECS), "result word appeared outside the last step")
	`GTES_ASSERT(a_hold_on_stall, clk, arst_n, (state_q == ST_SECS) && out_valid_q && !pop |=> state_q == ST_SECS, "converter left the last step while the output was held")
	`GTES_ASSERT(a_take_starts, clk, arst_n, rec_take |=> state_q == ST_QUOT, "taken date did not start a conversion")

endmodule

@@ design/generalized_time_to_epoch_seconds_unit.sv @@
// A result word follows the string's last character through the date queue and the converter
// steps QUOT, LEAP, DAYS, HOURS, MINS and SECS; an unpopped result word holds the converter in
// its last step. Throughput: one character per cycle while full is low; the converter takes a new
// string only in idle, once the last result word is placed, so strings that come faster back up in
// the queue and full then rises, holding all characters, until the converter catches up.
// Reset: arst_n clears position, queue and converter; characters are taken the next cycle.
module generalized_time_to_epoch_seconds_unit import gtes_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  item,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	logic      accept;
	logic      rec_push;
	date_rec_t rec_in, rec_out;
	logic      q_empty;
	logic      rec_take;

	assign accept = push && !full;

	gtes_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	gtes_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_in),
		.full    (full),
		.rd_en   (rec_take),
		.rd_data (rec_out),
		.empty   (q_empty)
	);

	gtes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (!q_empty),
		.rec       (rec_out),
		.rec_take  (rec_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
